>>> hw/rtl/svp_pkg.sv
`default_nettype none

package svp_pkg;

    // Fixed field widths of the two channels.
    localparam int SUPPORT_W  = 64;
    localparam int MEMBER_W   = 32;
    localparam int GROUP_W    = 5;

    // The member mask carries one bit per slot, so the store never holds more.
    localparam int SLOT_LIMIT = 32;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_START = 6'b000010,
        S_SEED  = 6'b000100,
        S_FETCH = 6'b001000,
        S_SWEEP = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/svp_in_if.sv
`default_nettype none

interface svp_in_if;
    import svp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SUPPORT_W-1:0] support_mask;
    logic                 enabled;
    logic                 is_vector;
    logic                 last;

    modport source (output valid, output support_mask, output enabled,
                    output is_vector, output last, input ready);
    modport sink   (input valid, input support_mask, input enabled,
                    input is_vector, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/svp_out_if.sv
`default_nettype none

interface svp_out_if;
    import svp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MEMBER_W-1:0]  member_mask;
    logic [SUPPORT_W-1:0] var_union;
    logic [GROUP_W-1:0]   group_index;
    logic                 no_groups;
    logic                 overflowed;
    logic                 end_of_run;

    modport source (output valid, output member_mask, output var_union,
                    output group_index, output no_groups, output overflowed,
                    output end_of_run, input ready);
    modport sink   (input valid, input member_mask, input var_union,
                    input group_index, input no_groups, input overflowed,
                    input end_of_run, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/svp_store.sv
`default_nettype none

module svp_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int WIDTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    // Support masks, one per slot. Entries are only read after being written.
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/svp_merge.sv
`default_nettype none

module svp_merge #(
    parameter int WIDTH = 64
) (
    input  wire logic             i_eligible,
    input  wire logic [WIDTH-1:0] i_vars,
    input  wire logic [WIDTH-1:0] i_entry,
    output logic                  o_hit,
    output logic      [WIDTH-1:0] o_merged
);
    // A slot joins the group when it is still unassigned and shares a variable.
    assign o_hit    = i_eligible && ((i_vars & i_entry) != '0);
    assign o_merged = o_hit ? (i_vars | i_entry) : i_vars;

endmodule

`default_nettype wire

>>> hw/rtl/shared_variable_partitioner.sv
`default_nettype none

// Channel   Direction  Beat contents
// i_in      sink       support_mask, enabled, is_vector, last
// o_out     source     member_mask, var_union, group_index, no_groups,
//                      overflowed, end_of_run
//
// A constraint beat is taken while the block is loading.
// A beat with last starts a run: a check of the stored slots, then per group
// a step to pick the seed slot and one to fetch its mask, sweeps that visit
// each stored slot in turn, repeated until a sweep adds nothing, and a
// hand-over of the result. A sweep ends early once no slot is left, and a seed
// that is the last free slot needs no sweep at all. The single store read port
// and the shared merge unit make a sweep visit one slot at a time. Input is
// not ready during a run. A stalled result holds the sequencer in place. Reset
// is synchronous, active low; the mask store needs no clearing pass because
// only slots written in the run are read.

module shared_variable_partitioner #(
    parameter int MAX_CONSTRAINTS = 32,
    parameter int NUM_VARS        = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    svp_in_if.sink      i_in,
    svp_out_if.source   o_out
);
    import svp_pkg::*;

    localparam int SLOT_CAP = (MAX_CONSTRAINTS > SLOT_LIMIT) ? SLOT_LIMIT : MAX_CONSTRAINTS;
    localparam int SLOT_AW  = (SLOT_CAP > 1) ? $clog2(SLOT_CAP) : 1;
    localparam int CNT_W    = $clog2(SLOT_CAP + 1);

    // Lowest set slot of a pending vector.
    function automatic logic [SLOT_AW-1:0] lowest_slot(input logic [SLOT_CAP-1:0] bits);
        logic [SLOT_AW-1:0] idx;
        idx = '0;
        for (int i = SLOT_CAP - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = SLOT_AW'(i);
            end
        end
        return idx;
    endfunction

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [SLOT_CAP-1:0]   r_pend, n_pend;
    logic                  r_ovf, n_ovf;
    logic [SLOT_CAP-1:0]   r_left, n_left;
    logic [SLOT_CAP-1:0]   r_members, n_members;
    logic [NUM_VARS-1:0]   r_vars, n_vars;
    logic [SLOT_AW-1:0]    r_idx, n_idx;
    logic                  r_changed, n_changed;
    logic [GROUP_W-1:0]    r_grp, n_grp;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_none, n_out_none;
    logic                  r_out_end, n_out_end;

    logic                  in_acc;
    logic                  out_acc;
    logic                  we;
    logic [SLOT_AW-1:0]    waddr;
    logic [NUM_VARS-1:0]   rdata;
    logic [SLOT_AW-1:0]    seed_idx;
    logic                  hit;
    logic [NUM_VARS-1:0]   merged;
    logic                  last_slot;
    logic [MEMBER_W-1:0]   out_members;
    logic [SUPPORT_W-1:0]  out_vars;

    // Handshakes and the store write port.
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_acc    = o_out.valid && o_out.ready;
    assign i_in.ready = (r_state == S_LOAD);
    assign waddr      = r_count[SLOT_AW-1:0];
    assign we         = in_acc && i_in.enabled && !i_in.is_vector
                        && (r_count < CNT_W'(SLOT_CAP));
    assign seed_idx   = lowest_slot(r_left);
    assign last_slot  = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));

    svp_store #(
        .DEPTH (SLOT_CAP),
        .AW    (SLOT_AW),
        .WIDTH (NUM_VARS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_in.support_mask[NUM_VARS-1:0]),
        .i_raddr (n_idx),
        .o_rdata (rdata)
    );

    svp_merge #(
        .WIDTH (NUM_VARS)
    ) u_merge (
        .i_eligible (r_left[r_idx]),
        .i_vars     (r_vars),
        .i_entry    (rdata),
        .o_hit      (hit),
        .o_merged   (merged)
    );

    // Sequencer: load, seed a group, sweep to a fixpoint, hand over the result.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pend      = r_pend;
        n_ovf       = r_ovf;
        n_left      = r_left;
        n_members   = r_members;
        n_vars      = r_vars;
        n_idx       = r_idx;
        n_changed   = r_changed;
        n_grp       = r_grp;
        n_out_valid = r_out_valid;
        n_out_none  = r_out_none;
        n_out_end   = r_out_end;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (we) begin
                        n_pend[waddr] = 1'b1;
                        n_count       = r_count + CNT_W'(1);
                    end else if (i_in.enabled && !i_in.is_vector) begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_left = r_pend;
                if (r_pend == '0) begin
                    n_members   = '0;
                    n_vars      = '0;
                    n_out_none  = 1'b1;
                    n_out_end   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_EMIT;
                end else begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                n_idx            = seed_idx;
                n_members        = '0;
                n_members[seed_idx] = 1'b1;
                n_left[seed_idx] = 1'b0;
                n_state          = S_FETCH;
            end
            S_FETCH: begin
                // Read data now holds the seed's mask.
                n_vars     = rdata;
                n_idx      = '0;
                n_changed  = 1'b0;
                n_out_none = 1'b0;
                if (r_left == '0) begin
                    n_out_end   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_EMIT;
                end else begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                n_vars = merged;
                if (hit) begin
                    n_members[r_idx] = 1'b1;
                    n_left[r_idx]    = 1'b0;
                    n_changed        = 1'b1;
                end
                if (n_left == '0) begin
                    n_out_end   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_EMIT;
                end else if (last_slot) begin
                    if (hit || r_changed) begin
                        n_idx     = '0;
                        n_changed = 1'b0;
                    end else begin
                        n_out_end   = 1'b0;
                        n_out_valid = 1'b1;
                        n_state     = S_EMIT;
                    end
                end else begin
                    n_idx = r_idx + SLOT_AW'(1);
                end
            end
            S_EMIT: begin
                if (out_acc) begin
                    n_out_valid = 1'b0;
                    if (r_out_end) begin
                        n_pend  = '0;
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_grp   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_grp   = r_grp + GROUP_W'(1);
                        n_state = S_SEED;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control state is reset; group payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_pend      <= '0;
            r_ovf       <= 1'b0;
            r_grp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_ovf       <= n_ovf;
            r_grp       <= n_grp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_members  <= n_members;
        r_vars     <= n_vars;
        r_idx      <= n_idx;
        r_changed  <= n_changed;
        r_out_none <= n_out_none;
        r_out_end  <= n_out_end;
    end

    // Widen the group to the channel's field widths.
    always_comb begin
        out_members                 = '0;
        out_members[SLOT_CAP-1:0]   = r_members;
        out_vars                    = '0;
        out_vars[NUM_VARS-1:0]      = r_vars;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.member_mask = out_members;
    assign o_out.var_union   = out_vars;
    assign o_out.group_index = r_grp;
    assign o_out.no_groups   = r_out_none;
    assign o_out.overflowed  = r_ovf;
    assign o_out.end_of_run  = r_out_end;

    // Loading and result delivery never overlap.
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is offered");

    // A last beat closes the load phase.
    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last) |=> !i_in.ready)
        else $error("still loading after a last beat");

    // The empty result is a lone, all-zero group.
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.no_groups) |->
        (o_out.end_of_run && (o_out.member_mask == '0) && (o_out.group_index == '0)))
        else $error("malformed empty result");

    // A real group is nonempty and made of stored slots only.
    a_members_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.no_groups) |->
        ((r_members != '0) && ((r_members & ~r_pend) == '0)))
        else $error("group holds a slot that was not stored");

    // A slot is never both in the current group and still unassigned.
    a_left_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> ((r_left & r_members) == '0))
        else $error("slot both assigned and pending");

endmodule

`default_nettype wire
